// ----- hw/rtl/amseq_pkg.sv -----
package amseq_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    // Addressing modes.
    localparam logic [3:0] M_IMP = 4'd0;
    localparam logic [3:0] M_IMM = 4'd1;
    localparam logic [3:0] M_ZP  = 4'd2;
    localparam logic [3:0] M_ZPX = 4'd3;
    localparam logic [3:0] M_ZPY = 4'd4;
    localparam logic [3:0] M_REL = 4'd5;
    localparam logic [3:0] M_ABS = 4'd6;
    localparam logic [3:0] M_ABX = 4'd7;
    localparam logic [3:0] M_ABY = 4'd8;
    localparam logic [3:0] M_IND = 4'd9;
    localparam logic [3:0] M_IZX = 4'd10;
    localparam logic [3:0] M_IZY = 4'd11;

    // Result kinds.
    localparam logic [1:0] K_READ = 2'd0;
    localparam logic [1:0] K_DONE = 2'd1;
    localparam logic [1:0] K_ACK  = 2'd2;

    // Sequence phases: idle, or waiting for data byte one to four.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_BYTE1 = 3'd1;
    localparam logic [2:0] PH_BYTE2 = 3'd2;
    localparam logic [2:0] PH_BYTE3 = 3'd3;
    localparam logic [2:0] PH_BYTE4 = 3'd4;

    localparam logic [15:0] PAGE_MASK = 16'hFF00;
    localparam logic [7:0]  LOW_LAST  = 8'hFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  mode;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  read_data;
        logic [15:0] new_pc;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] read_address;
        logic [15:0] effective_address;
        logic [15:0] relative_offset;
        logic        page_crossed;
        logic [15:0] pc_now;
    } t_out_item;

    typedef struct packed {
        logic [15:0] program_counter;
        logic [2:0]  phase;
        logic [3:0]  held_mode;
        logic [7:0]  held_x;
        logic [7:0]  held_y;
        logic [7:0]  operand_low;
        logic [7:0]  operand_high;
        logic [7:0]  pointer_low;
    } t_state;

endpackage

// ----- hw/rtl/amseq_step.sv -----
module amseq_step (
    input  amseq_pkg::t_state    i_state,
    input  amseq_pkg::t_in_item  i_item,
    output amseq_pkg::t_state    o_state,
    output amseq_pkg::t_out_item o_result,
    output logic                 o_emit
);

    logic [15:0] pc_inc;
    logic [15:0] base_addr;
    logic [7:0]  index_sel;
    logic [15:0] indexed_addr;
    logic [15:0] ptr_addr;
    logic [15:0] ind_next;
    logic [7:0]  data;

    // Shared address arithmetic.
    always_comb begin
        data      = i_item.read_data;
        pc_inc    = i_state.program_counter + 16'd1;
        index_sel = (i_state.held_mode == amseq_pkg::M_ABX) ? i_state.held_x : i_state.held_y;
        if (i_state.held_mode == amseq_pkg::M_IZY) begin
            base_addr = {data, i_state.pointer_low};
        end else begin
            base_addr = {data, i_state.operand_low};
        end
        indexed_addr = base_addr + {8'd0, index_sel};
        ptr_addr     = {i_state.operand_high, i_state.operand_low};
        if (i_state.operand_low == amseq_pkg::LOW_LAST) begin
            ind_next = ptr_addr & amseq_pkg::PAGE_MASK;
        end else begin
            ind_next = ptr_addr + 16'd1;
        end
    end

    // Next state and result for one item.
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_emit   = 1'b0;
        unique case (i_item.operation)
            amseq_pkg::OP_START: begin
                o_state.held_mode = i_item.mode;
                o_state.held_x    = i_item.index_x;
                o_state.held_y    = i_item.index_y;
                o_emit            = 1'b1;
                o_state.phase     = amseq_pkg::PH_IDLE;
                o_result.kind     = amseq_pkg::K_DONE;
                if (i_item.mode == amseq_pkg::M_IMM) begin
                    o_result.effective_address = i_state.program_counter;
                    o_state.program_counter    = pc_inc;
                end else if (i_item.mode != amseq_pkg::M_IMP &&
                             i_item.mode <= amseq_pkg::M_IZY) begin
                    o_result.kind           = amseq_pkg::K_READ;
                    o_result.read_address   = i_state.program_counter;
                    o_state.program_counter = pc_inc;
                    o_state.phase           = amseq_pkg::PH_BYTE1;
                end
            end
            amseq_pkg::OP_LOAD: begin
                o_state.program_counter = i_item.new_pc;
                o_state.phase           = amseq_pkg::PH_IDLE;
                o_result.kind           = amseq_pkg::K_ACK;
                o_emit                  = 1'b1;
            end
            amseq_pkg::OP_DATA: begin
                if (i_state.phase != amseq_pkg::PH_IDLE) begin
                    // Completion is the common outcome; read steps override it.
                    o_emit        = 1'b1;
                    o_result.kind = amseq_pkg::K_DONE;
                    o_state.phase = amseq_pkg::PH_IDLE;
                    case (i_state.held_mode)
                        amseq_pkg::M_ZP: begin
                            o_result.effective_address = {8'd0, data};
                        end
                        amseq_pkg::M_ZPX: begin
                            o_result.effective_address = {8'd0, data + i_state.held_x};
                        end
                        amseq_pkg::M_ZPY: begin
                            o_result.effective_address = {8'd0, data + i_state.held_y};
                        end
                        amseq_pkg::M_REL: begin
                            o_result.relative_offset = {{8{data[7]}}, data};
                        end
                        amseq_pkg::M_ABS, amseq_pkg::M_ABX, amseq_pkg::M_ABY: begin
                            if (i_state.phase == amseq_pkg::PH_BYTE1) begin
                                o_state.operand_low     = data;
                                o_result.kind           = amseq_pkg::K_READ;
                                o_result.read_address   = i_state.program_counter;
                                o_state.program_counter = pc_inc;
                                o_state.phase           = amseq_pkg::PH_BYTE2;
                            end else if (i_state.held_mode == amseq_pkg::M_ABS) begin
                                o_result.effective_address = {data, i_state.operand_low};
                            end else begin
                                o_result.effective_address = indexed_addr;
                                o_result.page_crossed      = (indexed_addr[15:8] != data);
                            end
                        end
                        amseq_pkg::M_IND: begin
                            o_result.kind = amseq_pkg::K_READ;
                            if (i_state.phase == amseq_pkg::PH_BYTE1) begin
                                o_state.operand_low     = data;
                                o_result.read_address   = i_state.program_counter;
                                o_state.program_counter = pc_inc;
                                o_state.phase           = amseq_pkg::PH_BYTE2;
                            end else if (i_state.phase == amseq_pkg::PH_BYTE2) begin
                                o_state.operand_high  = data;
                                o_result.read_address = {data, i_state.operand_low};
                                o_state.phase         = amseq_pkg::PH_BYTE3;
                            end else if (i_state.phase == amseq_pkg::PH_BYTE3) begin
                                // The high byte comes from the same page as the pointer.
                                o_state.pointer_low   = data;
                                o_result.read_address = ind_next;
                                o_state.phase         = amseq_pkg::PH_BYTE4;
                            end else begin
                                o_result.kind              = amseq_pkg::K_DONE;
                                o_result.effective_address = {data, i_state.pointer_low};
                            end
                        end
                        amseq_pkg::M_IZX, amseq_pkg::M_IZY: begin
                            o_result.kind = amseq_pkg::K_READ;
                            if (i_state.phase == amseq_pkg::PH_BYTE1) begin
                                if (i_state.held_mode == amseq_pkg::M_IZX) begin
                                    o_state.operand_low = data + i_state.held_x;
                                end else begin
                                    o_state.operand_low = data;
                                end
                                o_result.read_address = {8'd0, o_state.operand_low};
                                o_state.phase         = amseq_pkg::PH_BYTE2;
                            end else if (i_state.phase == amseq_pkg::PH_BYTE2) begin
                                o_state.pointer_low   = data;
                                o_result.read_address = {8'd0, i_state.operand_low + 8'd1};
                                o_state.phase         = amseq_pkg::PH_BYTE3;
                            end else if (i_state.held_mode == amseq_pkg::M_IZX) begin
                                o_result.kind              = amseq_pkg::K_DONE;
                                o_result.effective_address = {data, i_state.pointer_low};
                            end else begin
                                o_result.kind              = amseq_pkg::K_DONE;
                                o_result.effective_address = indexed_addr;
                                o_result.page_crossed      = (indexed_addr[15:8] != data);
                            end
                        end
                        default: begin
                            // A mode with no sequence: drop the item and go idle.
                            o_emit = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                o_emit = 1'b0;
            end
        endcase
        o_result.pc_now = o_state.program_counter;
    end

endmodule

// ----- hw/rtl/addressing_mode_sequencer_core.sv -----
// Effective-address sequencer for the eight-bit processor addressing modes.
// Input channel (i_in_valid / o_in_ready / i_in_item): a start item names the
// mode and brings X and Y; each bus read byte returns as a data item; a load
// item sets the program counter. Output channel (o_out_valid / i_out_ready /
// o_out_item): one item per start, load, or data item taken while a sequence
// runs: a read request, a completed address or a load acknowledge.
// An item taken waits in the input register; its result goes from the address
// logic into the output register. Throughput is one item per cycle unless the
// receiver stalls: the input register feeds the address logic, whose result
// and state update land in the output and state registers in the same cycle.
// When the receiver stalls, the result waits in the output register and one
// further item may wait in the input register; o_in_ready then falls.
// Data items while idle produce nothing, but they still wait in the input
// register while a stalled result holds the output register.
// Synchronous reset clears both registers' valid flags, the program counter
// and the sequence state; the block takes items in the first cycle after it.
module addressing_mode_sequencer_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  amseq_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output amseq_pkg::t_out_item o_out_item
);

    logic                 r_in_valid;
    amseq_pkg::t_in_item  r_in_item;
    amseq_pkg::t_state    r_state;
    amseq_pkg::t_state    n_state;
    amseq_pkg::t_out_item n_result;
    logic                 n_emit;
    logic                 r_out_valid;
    amseq_pkg::t_out_item r_out_item;
    logic                 stage_go;

    // The input stage moves on when the output register is free or draining.
    assign stage_go   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || stage_go;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    // Address logic for the item in the input register.
    amseq_step u_step (
        .i_state  (r_state),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_result),
        .o_emit   (n_emit)
    );

    // Sequence state and program counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (stage_go) begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_go && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_go && n_emit) begin
            r_out_item <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef ASSERT_OFF
    // The phase never leaves the range of the longest sequence.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase <= amseq_pkg::PH_BYTE4)
        else $error("sequence phase out of range");

    // Issuing a read request always leaves a sequence running.
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_go && n_emit && n_result.kind == amseq_pkg::K_READ
        |=> r_state.phase != amseq_pkg::PH_IDLE)
        else $error("read request issued with no sequence running");

    // Completions and acknowledges end the sequence.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_go && n_emit && n_result.kind != amseq_pkg::K_READ
        |=> r_state.phase == amseq_pkg::PH_IDLE)
        else $error("sequence still running after completion");

    // A page crossing is only reported with a completed address.
    a_cross_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.page_crossed |-> o_out_item.kind == amseq_pkg::K_DONE)
        else $error("page crossing flagged outside a completion");
`endif

endmodule
